### hdl/dnbdf_pkg.sv
// ----------------------------------------------------------------------------
// dnbdf_pkg
// Shared types and constants for the dual-number Code-B digit formatter.
// ----------------------------------------------------------------------------
package dnbdf_pkg;

    localparam int NUM_DIGITS  = 8;
    localparam int HALF_DIGITS = 4;
    localparam int IDX_W       = $clog2(NUM_DIGITS);

    typedef logic [3:0] digit_t;
    typedef digit_t [HALF_DIGITS-1:0] half_digits_t;
    typedef digit_t [NUM_DIGITS-1:0]  all_digits_t;

    localparam digit_t CODE_MINUS = 4'hA;
    localparam digit_t CODE_BLANK = 4'hF;
    localparam digit_t CODE_NINE  = 4'h9;

    // Reciprocal constants: floor(x * RECIP >> SHIFT) equals floor(x / divisor)
    // over the value range of each stage.
    localparam logic [16:0] RECIP_1000 = 17'd67109;
    localparam int          SHIFT_1000 = 26;
    localparam logic [7:0]  RECIP_10   = 8'd205;
    localparam int          SHIFT_10   = 11;
    localparam logic [5:0]  RECIP_100  = 6'd41;
    localparam int          SHIFT_100  = 12;

endpackage

### hdl/dnbdf_conv.sv
// ----------------------------------------------------------------------------
// dnbdf_conv
// Four-stage converter: one 16-bit number to four Code-B digits.
// ----------------------------------------------------------------------------
module dnbdf_conv (
    input  logic                    aclk,
    input  logic                    en,
    input  logic                    mode,
    input  logic [15:0]             value,
    output dnbdf_pkg::half_digits_t digits
);
    import dnbdf_pkg::*;

    logic [15:0] mag;
    logic        neg;
    logic [32:0] prod_t;
    logic [15:0] r_full;
    logic [14:0] prod_qt;
    logic [3:0]  qt;
    logic [6:0]  d3_full;
    logic [15:0] prod_h;
    logic [9:0]  rem_full;
    logic [6:0]  rem;
    logic [14:0] prod_tens;
    logic [3:0]  tens;
    logic [6:0]  ones_full;

    logic [15:0] mag1_reg;
    logic [6:0]  t1_reg;
    logic        mode1_reg, neg1_reg;
    logic [9:0]  r2_reg;
    logic [6:0]  t2_reg;
    logic        mode2_reg, neg2_reg;
    logic [9:0]  r3_reg;
    logic [3:0]  h3_reg;
    digit_t      d3_reg;
    logic        mode3_reg, neg3_reg;
    half_digits_t digits_reg;
    half_digits_t digits_next;

    // thousands count
    always_comb begin
        neg    = mode & value[15];
        mag    = neg ? (~value + 16'd1) : value;
        prod_t = 33'(mag) * 33'(RECIP_1000);
    end

    // remainder below one thousand
    always_comb begin
        r_full = mag1_reg - (16'(t1_reg) * 16'd1000);
    end

    // thousands digit and hundreds digit
    always_comb begin
        prod_qt = 15'(t2_reg) * 15'(RECIP_10);
        qt      = prod_qt[14:SHIFT_10];
        d3_full = t2_reg - (7'(qt) * 7'd10);
        prod_h  = 16'(r2_reg) * 16'(RECIP_100);
    end

    // tens and ones
    always_comb begin
        rem_full  = r3_reg - (10'(h3_reg) * 10'd100);
        rem       = rem_full[6:0];
        prod_tens = 15'(rem) * 15'(RECIP_10);
        tens      = prod_tens[14:SHIFT_10];
        ones_full = rem - (7'(tens) * 7'd10);
        digits_next[0] = ones_full[3:0];
        digits_next[1] = tens;
        digits_next[2] = h3_reg;
        if (mode3_reg) begin
            digits_next[3] = neg3_reg ? CODE_MINUS : CODE_BLANK;
        end else begin
            digits_next[3] = d3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg   <= mag;
            t1_reg     <= prod_t[32:SHIFT_1000];
            mode1_reg  <= mode;
            neg1_reg   <= neg;
            r2_reg     <= r_full[9:0];
            t2_reg     <= t1_reg;
            mode2_reg  <= mode1_reg;
            neg2_reg   <= neg1_reg;
            r3_reg     <= r2_reg;
            h3_reg     <= prod_h[15:SHIFT_100];
            d3_reg     <= d3_full[3:0];
            mode3_reg  <= mode2_reg;
            neg3_reg   <= neg2_reg;
            digits_reg <= digits_next;
        end
    end

    assign digits = digits_reg;

endmodule

### hdl/dnbdf_emit.sv
// ----------------------------------------------------------------------------
// dnbdf_emit
// Digit buffer and write sequencer: eight digit writes per loaded number pair.
// ----------------------------------------------------------------------------
module dnbdf_emit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load_valid,
    input  dnbdf_pkg::all_digits_t load_digits,
    output logic                   take,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [3:0]             m_digit_register,
    output logic [3:0]             m_digit_code,
    output logic                   m_last_digit
);
    import dnbdf_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIGITS - 1);

    digit_t           buf_reg [NUM_DIGITS];
    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             xfer;
    logic             done;

    always_comb begin
        xfer = busy_reg & m_ready;
        done = xfer & (idx_reg == LAST_IDX);
        take = load_valid & (~busy_reg | done);
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (take) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (xfer) begin
            idx_next = idx_reg + IDX_W'(1);
            if (done) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                buf_reg[i] <= load_digits[i];
            end
        end
    end

    assign m_valid          = busy_reg;
    assign m_digit_register = 4'(idx_reg) + 4'd1;
    assign m_digit_code     = buf_reg[idx_reg];
    assign m_last_digit     = (idx_reg == LAST_IDX);

endmodule

### hdl/dual_number_bcd_digit_formatter.sv
// An input transfer passes the input register and the four converter stages
// before its digits load the digit buffer. New items may enter while a pair is
// written out, one digit write per cycle through the result port while m_ready is high.
// Input register, 4-stage converter and digit buffer run concurrently.
// Reset (aresetn low, synchronous) empties the pipeline and the sequencer.
// ----------------------------------------------------------------------------
// dual_number_bcd_digit_formatter
// Two 16-bit numbers to eight Code-B digit writes, rightmost digit first.
// ----------------------------------------------------------------------------
module dual_number_bcd_digit_formatter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [15:0] s_left_value,
    input  logic [15:0] s_right_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_digit_register,
    output logic [3:0]  m_digit_code,
    output logic        m_last_digit
);
    import dnbdf_pkg::*;

    localparam int PIPE_STAGES = 5;

    logic                   mode_reg;
    logic [15:0]            left_reg, right_reg;
    logic [PIPE_STAGES-1:0] vld_reg;
    logic                   adv;
    logic                   take;
    half_digits_t           left_digits, right_digits;
    all_digits_t            all_digits;

    assign adv     = ~vld_reg[PIPE_STAGES-1] | take;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_STAGES-2:0], s_valid};
        end
    end

    // hold the input item while the pipeline stalls
    always_ff @(posedge aclk) begin
        if (adv) begin
            mode_reg  <= s_mode;
            left_reg  <= s_left_value;
            right_reg <= s_right_value;
        end
    end

    dnbdf_conv u_conv_right (
        .aclk   (aclk),
        .en     (adv),
        .mode   (mode_reg),
        .value  (right_reg),
        .digits (right_digits)
    );

    dnbdf_conv u_conv_left (
        .aclk   (aclk),
        .en     (adv),
        .mode   (mode_reg),
        .value  (left_reg),
        .digits (left_digits)
    );

    assign all_digits = {left_digits, right_digits};

    dnbdf_emit u_emit (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load_valid       (vld_reg[PIPE_STAGES-1]),
        .load_digits      (all_digits),
        .take             (take),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_digit_register (m_digit_register),
        .m_digit_code     (m_digit_code),
        .m_last_digit     (m_last_digit)
    );

`ifndef NO_ASSERTIONS
    a_last_on_top_register: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_digit == (m_digit_register == 4'(NUM_DIGITS))))
        else $error("last_digit does not match the top register");

    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_digit && !take) |=> !m_valid)
        else $error("digit run continues past the last transfer");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[PIPE_STAGES-1] |-> s_ready)
        else $error("input stalled with an empty converter output");

    a_code_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_digit_code <= CODE_NINE || m_digit_code == CODE_MINUS ||
                     m_digit_code == CODE_BLANK))
        else $error("illegal Code-B value");
`endif

endmodule
